[src/wsht_pkg.sv]
`default_nettype none

package wsht_pkg;

    // Default sizes handed to the top level.
    localparam int MAX_FRAMES_DEF  = 64;
    localparam int HEIGHT_BITS_DEF = 16;

    // Fixed part of a frame entry: end arity, branch arity and polymorphic mark.
    localparam int FRAME_FIXED_W = 17;

    // Height of an empty activation and the ceiling of the reported cost.
    localparam int          ACT_FRAME_COST = 2;
    localparam logic [16:0] COST_MAX       = 17'd131071;

    // Event codes on the input channel.
    typedef enum logic [3:0] {
        OP_START       = 4'd0,
        OP_BLOCK       = 4'd1,
        OP_IF          = 4'd2,
        OP_ELSE        = 4'd3,
        OP_END         = 4'd4,
        OP_PLAIN       = 4'd5,
        OP_BR          = 4'd6,
        OP_BR_IF       = 4'd7,
        OP_TABLE       = 4'd8,
        OP_RETURN      = 4'd9,
        OP_UNREACHABLE = 4'd10
    } t_op;

    // Status codes on the result channel.
    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_NO_FRAME       = 3'd1,
        ST_BELOW_FRAME    = 3'd2,
        ST_UNDERFLOW      = 3'd3,
        ST_BAD_DEPTH      = 3'd4,
        ST_TABLE_MISMATCH = 3'd5
    } t_status;

    // One input event.
    typedef struct packed {
        logic [3:0]  operation;
        logic [7:0]  first_pop;
        logic [7:0]  second_pop;
        logic [7:0]  push_count;
        logic [5:0]  depth;
        logic        has_result;
        logic        is_loop;
        logic [15:0] local_count;
        logic [7:0]  result_count;
        logic        table_last;
    } t_item;

    // One result.
    typedef struct packed {
        t_status     status;
        logic        done_res;
        logic [16:0] stack_cost;
        logic [15:0] height;
    } t_result;

endpackage

`default_nettype wire

[src/wasm_stack_height_tracker.sv]
`default_nettype none

// Pipeline: a result passes through the accept stage register and then the output register.
// Throughput: one event per cycle while the output is taken; the frame memory read is issued at acceptance
// and a write to the same entry in that cycle is forwarded from a bypass register.
// Reset: synchronous, active low; clears the pipeline and the tracker state.
// The frame memory is not cleared; only entries written since the last start are read.
module wasm_stack_height_tracker #(
    parameter int MAX_FRAMES  = wsht_pkg::MAX_FRAMES_DEF,
    parameter int HEIGHT_BITS = wsht_pkg::HEIGHT_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [3:0]  i_operation,
    input  wire logic [7:0]  i_first_pop,
    input  wire logic [7:0]  i_second_pop,
    input  wire logic [7:0]  i_push_count,
    input  wire logic [5:0]  i_depth,
    input  wire logic        i_has_result,
    input  wire logic        i_is_loop,
    input  wire logic [15:0] i_local_count,
    input  wire logic [7:0]  i_result_count,
    input  wire logic        i_table_last,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_status,
    output logic             o_done_res,
    output logic [16:0]      o_stack_cost,
    output logic [15:0]      o_height
);

    import wsht_pkg::*;

    localparam int AW      = $clog2(MAX_FRAMES);
    localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
    localparam int DW      = (CNT_W > 6) ? CNT_W : 6;
    localparam int FRAME_W = HEIGHT_BITS + FRAME_FIXED_W;

    t_item            in_item;
    logic             accept;
    logic             advance;

    logic             r_s1_valid;
    t_item            r_s1_item;
    logic [CNT_W-1:0] r_pcnt, n_pcnt;
    logic [DW-1:0]    raddr_full;
    logic [AW-1:0]    raddr;

    logic             r_fwd_hit;
    logic [FRAME_W-1:0] r_fwd_data;
    logic [FRAME_W-1:0] mem_rdata;
    logic [FRAME_W-1:0] rd_frame;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [FRAME_W-1:0] wr_data;

    t_result          exec_result;
    logic             r_out_valid;
    t_result          r_out;

    assign in_item = '{operation: i_operation, first_pop: i_first_pop,
                       second_pop: i_second_pop, push_count: i_push_count,
                       depth: i_depth, has_result: i_has_result, is_loop: i_is_loop,
                       local_count: i_local_count, result_count: i_result_count,
                       table_last: i_table_last};

    // Handshake: the execute stage moves on whenever the output register frees up.
    assign advance    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || advance;
    assign accept     = i_in_valid && o_in_ready;

    // Frame count as seen by the next event; it runs ahead of the execute stage.
    // After an error it may drift, but every event until the next start is ignored.
    always_comb begin
        case (i_operation)
            OP_START:        n_pcnt = CNT_W'(1);
            OP_BLOCK, OP_IF: n_pcnt = r_pcnt + 1'b1;
            OP_END:          n_pcnt = r_pcnt - 1'b1;
            default:         n_pcnt = r_pcnt;
        endcase
    end

    // An end reads the frame below the top; a branch reads its target frame.
    assign raddr_full = (i_operation == OP_END) ? (DW'(r_pcnt) - DW'(2))
                                                : (DW'(r_pcnt) - DW'(1) - DW'(i_depth));
    assign raddr      = raddr_full[AW-1:0];

    // Accept stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_pcnt     <= '0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_pcnt     <= n_pcnt;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Item payload and bypass of a write that lands in the same cycle as the read.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item  <= in_item;
            r_fwd_hit  <= wr_en && (wr_addr == raddr);
            r_fwd_data <= wr_data;
        end
    end

    assign rd_frame = r_fwd_hit ? r_fwd_data : mem_rdata;

    wsht_frame_mem #(
        .ADDR_W (AW),
        .DATA_W (FRAME_W)
    ) u_frame_mem (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (accept),
        .i_raddr (raddr),
        .o_rdata (mem_rdata)
    );

    wsht_exec #(
        .MAX_FRAMES  (MAX_FRAMES),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_exec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (advance),
        .i_item     (r_s1_item),
        .i_rd_frame (rd_frame),
        .o_result   (exec_result),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= exec_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out.status;
    assign o_done_res   = r_out.done_res;
    assign o_stack_cost = r_out.stack_cost;
    assign o_height     = r_out.height;

endmodule

`default_nettype wire

[src/wsht_frame_mem.sv]
`default_nettype none

module wsht_frame_mem #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 33
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [0:(1 << ADDR_W)-1];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[src/wsht_exec.sv]
`default_nettype none

module wsht_exec #(
    parameter int MAX_FRAMES  = 64,
    parameter int HEIGHT_BITS = 16
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_rst_n,
    input  wire logic                                         i_fire,
    input  wire wsht_pkg::t_item                              i_item,
    input  wire logic [HEIGHT_BITS+wsht_pkg::FRAME_FIXED_W-1:0] i_rd_frame,
    output wsht_pkg::t_result                                 o_result,
    output logic                                              o_wr_en,
    output logic [$clog2(MAX_FRAMES)-1:0]                     o_wr_addr,
    output logic [HEIGHT_BITS+wsht_pkg::FRAME_FIXED_W-1:0]      o_wr_data
);

    import wsht_pkg::*;

    localparam int HB    = HEIGHT_BITS;
    localparam int AW    = $clog2(MAX_FRAMES);
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int DW    = (CNT_W > 6) ? CNT_W : 6;
    localparam int SW    = ((HB > 16) ? HB : 16) + 1;

    typedef struct packed {
        logic [HB-1:0] start;
        logic [7:0]    end_ar;
        logic [7:0]    br_ar;
        logic          poly;
    } t_frame;

    typedef struct packed {
        t_status       st;
        logic [HB-1:0] h;
    } t_pop;

    // Pop n values from height h against the top frame.
    function automatic t_pop pop_vals(input logic [HB-1:0] h, input logic [7:0] n,
                                      input logic [HB-1:0] start, input logic poly);
        t_pop          res;
        logic [HB-1:0] n_ext;
        res.st = ST_OK;
        res.h  = h;
        n_ext  = HB'(n);
        if (n != 8'd0) begin
            if (n_ext > h) begin
                res.st = ST_UNDERFLOW;
            end else if ((h - n_ext) < start) begin
                if (!poly) begin
                    res.st = ST_BELOW_FRAME;
                end
            end else begin
                res.h = h - n_ext;
            end
        end
        return res;
    endfunction

    // Push n values, saturating at the height range.
    function automatic logic [HB-1:0] push_vals(input logic [HB-1:0] h, input logic [7:0] n);
        logic [HB:0] sum;
        sum = {1'b0, h} + (HB+1)'(n);
        return sum[HB] ? {HB{1'b1}} : sum[HB-1:0];
    endfunction

    // Tracker state.
    logic [CNT_W-1:0] r_count, n_count;
    logic [HB-1:0]    r_height, n_height;
    logic [HB-1:0]    r_max, n_max;
    logic [15:0]      r_locals, n_locals;
    logic [7:0]       r_func_res, n_func_res;
    logic [7:0]       r_table_ar, n_table_ar;
    logic             r_in_table, n_in_table;
    logic             r_saw, n_saw;
    logic             r_failed, n_failed;
    t_frame           r_top, n_top;

    // Working values of the current event.
    t_frame           rd;
    t_status          st;
    logic [HB-1:0]    h;
    t_pop             p1, p2;
    logic             instr;
    logic             depth_ok;
    logic [7:0]       tgt_ar;
    logic             do_push;
    t_frame           new_frame;
    logic             done;
    logic [16:0]      cost;
    logic [SW-1:0]    cost_sum;

    assign rd       = i_rd_frame;
    assign depth_ok = DW'(i_item.depth) < DW'(r_count);
    assign tgt_ar   = (i_item.depth == 6'd0) ? r_top.br_ar : rd.br_ar;
    assign cost_sum = r_saw ? (SW'(r_max) + SW'(r_locals))
                            : (SW'(r_locals) + SW'(ACT_FRAME_COST));

    // Event execution against the top frame held in registers.
    always_comb begin
        n_count    = r_count;
        n_max      = r_max;
        n_locals   = r_locals;
        n_func_res = r_func_res;
        n_table_ar = r_table_ar;
        n_in_table = r_in_table;
        n_saw      = r_saw;
        n_failed   = r_failed;
        n_top      = r_top;
        h          = r_height;
        st         = ST_OK;
        p1         = '0;
        p2         = '0;
        instr      = 1'b0;
        do_push    = 1'b0;
        new_frame  = '0;
        done       = 1'b0;
        cost       = '0;
        o_wr_en    = 1'b0;

        if (i_item.operation == OP_START) begin
            n_count    = CNT_W'(1);
            h          = HB'(ACT_FRAME_COST);
            n_max      = '0;
            n_locals   = i_item.local_count;
            n_func_res = i_item.result_count;
            n_table_ar = '0;
            n_in_table = 1'b0;
            n_saw      = 1'b0;
            n_failed   = 1'b0;
            n_top      = '{start: '0, end_ar: i_item.result_count,
                           br_ar: i_item.result_count, poly: 1'b0};
        end else if (r_failed) begin
            st = ST_NO_FRAME;
        end else if (i_item.operation <= OP_UNREACHABLE) begin
            if (r_in_table && i_item.operation != OP_TABLE) begin
                n_in_table = 1'b0;
            end
            if (r_count == '0) begin
                st = ST_NO_FRAME;
            end else begin
                instr = (i_item.operation != OP_ELSE && i_item.operation != OP_END &&
                         i_item.operation != OP_TABLE) ||
                        (i_item.operation == OP_TABLE && !r_in_table);
                // Running maximum is taken before the instruction.
                if (instr) begin
                    n_saw = 1'b1;
                    if (!r_top.poly && r_height > r_max) begin
                        n_max = r_height;
                    end
                end
                case (i_item.operation)
                    OP_BLOCK: begin
                        do_push   = 1'b1;
                        new_frame = '{start: h, end_ar: {7'd0, i_item.has_result},
                                      br_ar: i_item.is_loop ? 8'd0 : {7'd0, i_item.has_result},
                                      poly: 1'b0};
                    end
                    OP_IF: begin
                        p1 = pop_vals(h, 8'd1, r_top.start, r_top.poly);
                        h  = p1.h;
                        st = p1.st;
                        if (st == ST_OK) begin
                            do_push   = 1'b1;
                            new_frame = '{start: h, end_ar: {7'd0, i_item.has_result},
                                          br_ar: {7'd0, i_item.has_result}, poly: 1'b0};
                        end
                    end
                    OP_ELSE: begin
                        h          = r_top.start;
                        n_top.poly = 1'b0;
                    end
                    OP_END: begin
                        h       = push_vals(r_top.start, r_top.end_ar);
                        n_count = r_count - 1'b1;
                        if (r_count == CNT_W'(1)) begin
                            done = 1'b1;
                            cost = (cost_sum > SW'(COST_MAX)) ? COST_MAX : cost_sum[16:0];
                        end else begin
                            n_top = rd;
                        end
                    end
                    OP_PLAIN: begin
                        p1 = pop_vals(h, i_item.first_pop, r_top.start, r_top.poly);
                        h  = p1.h;
                        st = p1.st;
                        if (st == ST_OK) begin
                            p2 = pop_vals(h, i_item.second_pop, r_top.start, r_top.poly);
                            h  = p2.h;
                            st = p2.st;
                        end
                        if (st == ST_OK) begin
                            h = push_vals(h, i_item.push_count);
                        end
                    end
                    OP_BR: begin
                        if (!depth_ok) begin
                            st = ST_BAD_DEPTH;
                        end else begin
                            p1 = pop_vals(h, tgt_ar, r_top.start, r_top.poly);
                            h  = p1.h;
                            st = p1.st;
                            if (st == ST_OK) begin
                                n_top.poly = 1'b1;
                            end
                        end
                    end
                    OP_BR_IF: begin
                        if (!depth_ok) begin
                            st = ST_BAD_DEPTH;
                        end else begin
                            p1 = pop_vals(h, tgt_ar, r_top.start, r_top.poly);
                            h  = p1.h;
                            st = p1.st;
                            if (st == ST_OK) begin
                                p2 = pop_vals(h, 8'd1, r_top.start, r_top.poly);
                                h  = p2.h;
                                st = p2.st;
                            end
                            if (st == ST_OK) begin
                                h = push_vals(h, tgt_ar);
                            end
                        end
                    end
                    OP_TABLE: begin
                        if (!depth_ok) begin
                            st = ST_BAD_DEPTH;
                        end else if (!r_in_table) begin
                            n_table_ar = tgt_ar;
                            n_in_table = 1'b1;
                        end else if (tgt_ar != r_table_ar) begin
                            st = ST_TABLE_MISMATCH;
                        end
                        // The last entry pops the common arity and ends the table.
                        if (st == ST_OK && i_item.table_last) begin
                            n_in_table = 1'b0;
                            p1 = pop_vals(h, tgt_ar, r_top.start, r_top.poly);
                            h  = p1.h;
                            st = p1.st;
                            if (st == ST_OK) begin
                                n_top.poly = 1'b1;
                            end
                        end
                    end
                    OP_RETURN: begin
                        p1 = pop_vals(h, r_func_res, r_top.start, r_top.poly);
                        h  = p1.h;
                        st = p1.st;
                        if (st == ST_OK) begin
                            n_top.poly = 1'b1;
                        end
                    end
                    default: begin
                        n_top.poly = 1'b1;
                    end
                endcase
                // Opening a frame spills the old top into the frame memory.
                if (do_push) begin
                    if (r_count >= CNT_W'(MAX_FRAMES)) begin
                        st = ST_BAD_DEPTH;
                    end else begin
                        o_wr_en = i_fire;
                        n_top   = new_frame;
                        n_count = r_count + 1'b1;
                    end
                end
            end
            if (st != ST_OK) begin
                n_failed = 1'b1;
            end
        end
        n_height = h;
    end

    assign o_wr_addr = AW'(r_count - 1'b1);
    assign o_wr_data = r_top;

    assign o_result = '{status: st, done_res: done, stack_cost: cost, height: 16'(h)};

    // Control state, updated once per executed event.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_height   <= HB'(ACT_FRAME_COST);
            r_max      <= '0;
            r_locals   <= '0;
            r_func_res <= '0;
            r_table_ar <= '0;
            r_in_table <= 1'b0;
            r_saw      <= 1'b0;
            r_failed   <= 1'b0;
        end else if (i_fire) begin
            r_count    <= n_count;
            r_height   <= n_height;
            r_max      <= n_max;
            r_locals   <= n_locals;
            r_func_res <= n_func_res;
            r_table_ar <= n_table_ar;
            r_in_table <= n_in_table;
            r_saw      <= n_saw;
            r_failed   <= n_failed;
        end
    end

    // Cached top frame; only read while a frame is open.
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_top <= n_top;
        end
    end

endmodule

`default_nettype wire
